// File: hw/rtl/rpcd_pkg.sv
// Shared types, codes and constants of the RPC frame deframer.
`timescale 1ns / 1ps

package rpcd_pkg;

  // Fixed frame layout.
  localparam int unsigned HEADER_OVERHEAD = 26;
  localparam int unsigned LENGTH_BYTES    = 4;
  localparam int unsigned TAIL_BYTES      = 5;

  // Width of frame lengths and byte counters (bounded by the frame limit).
  localparam int unsigned LEN_W = 24;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [1:0] CFG_MAX_FIELD    = 2'd2;
  localparam logic [1:0] CFG_MAX_FRAME    = 2'd3;

  // Parse phases.
  localparam logic [3:0] PH_HUNT       = 4'd0;
  localparam logic [3:0] PH_FRAME_LEN  = 4'd1;
  localparam logic [3:0] PH_ID_LEN     = 4'd2;
  localparam logic [3:0] PH_ID         = 4'd3;
  localparam logic [3:0] PH_METHOD_LEN = 4'd4;
  localparam logic [3:0] PH_METHOD     = 4'd5;
  localparam logic [3:0] PH_ERR_CODE   = 4'd6;
  localparam logic [3:0] PH_INFO_LEN   = 4'd7;
  localparam logic [3:0] PH_INFO       = 4'd8;
  localparam logic [3:0] PH_PAYLOAD    = 4'd9;
  localparam logic [3:0] PH_CHECKSUM   = 4'd10;
  localparam logic [3:0] PH_END        = 4'd11;

  // Result kinds.
  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_WORD    = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Field tags.
  localparam logic [1:0] TAG_ID      = 2'd0;
  localparam logic [1:0] TAG_METHOD  = 2'd1;
  localparam logic [1:0] TAG_INFO    = 2'd2;
  localparam logic [1:0] TAG_PAYLOAD = 2'd3;

  // Frame status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_END = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0]       start_marker;
    logic [7:0]       end_marker;
    logic [15:0]      max_field;
    logic [LEN_W-1:0] max_frame;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         tag;
    logic [7:0]         data;
    logic signed [31:0] err_word;
    logic [1:0]         status;
    logic               last;
  } res_t;

endpackage

// File: hw/rtl/rpcd_in_stage.sv
// Input register stage: holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module rpcd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       load;

  // The stage stalls only while it is full and its word is not taken.
  assign in_stall_o = vld_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

// File: hw/rtl/rpcd_parser.sv
// Frame parser: phase state and the per-byte decode logic.
`timescale 1ns / 1ps

module rpcd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          rx_byte_i,
  input  rpcd_pkg::cfg_t      cfg_i,
  output logic                res_vld_o,
  output rpcd_pkg::res_t      res_o
);

  localparam int unsigned LW = rpcd_pkg::LEN_W;

  logic [3:0]    ph_q, ph_d;
  logic [1:0]    wcnt_q, wcnt_d;
  logic [23:0]   acc_q, acc_d;
  logic [LW-1:0] bleft_q, bleft_d;
  logic [LW-1:0] fbl_q, fbl_d;
  logic [LW-1:0] sum_q, sum_d;
  logic [LW-1:0] flen_q, flen_d;

  logic [31:0]   word_full;
  logic          word_done;
  logic [LW-1:0] fbl_dec;
  logic [LW-1:0] bleft_dec;
  logic [LW-1:0] pay_len;
  logic [LW:0]   len_total;
  logic [LW:0]   len_room;
  logic          len_err;
  logic          len_zero;
  logic [1:0]    ctag;

  // Shared arithmetic for the current byte.
  assign word_full = {acc_q, rx_byte_i};
  assign word_done = (wcnt_q == 2'(rpcd_pkg::LENGTH_BYTES - 1));
  assign fbl_dec   = fbl_q - LW'(1);
  assign bleft_dec = bleft_q - LW'(1);
  assign pay_len   = fbl_dec - LW'(rpcd_pkg::TAIL_BYTES);
  assign len_total = {1'b0, sum_q} + (LW + 1)'(word_full[15:0]);
  assign len_room  = {1'b0, flen_q - LW'(rpcd_pkg::HEADER_OVERHEAD)};
  assign len_zero  = (word_full == 32'd0);
  assign len_err   = (word_full > {16'd0, cfg_i.max_field}) || (len_total > len_room);

  // Tag of a content phase.
  always_comb begin
    unique case (ph_q)
      rpcd_pkg::PH_ID:     ctag = rpcd_pkg::TAG_ID;
      rpcd_pkg::PH_METHOD: ctag = rpcd_pkg::TAG_METHOD;
      rpcd_pkg::PH_INFO:   ctag = rpcd_pkg::TAG_INFO;
      default:             ctag = rpcd_pkg::TAG_PAYLOAD;
    endcase
  end

  // Next state and result for one byte.
  always_comb begin
    ph_d      = ph_q;
    wcnt_d    = wcnt_q;
    acc_d     = acc_q;
    bleft_d   = bleft_q;
    fbl_d     = fbl_q;
    sum_d     = sum_q;
    flen_d    = flen_q;
    res_vld_o = 1'b0;
    res_o     = '0;

    unique case (ph_q)
      rpcd_pkg::PH_HUNT: begin
        if (rx_byte_i == cfg_i.start_marker) begin
          ph_d   = rpcd_pkg::PH_FRAME_LEN;
          wcnt_d = 2'd0;
          acc_d  = 24'd0;
          sum_d  = '0;
        end
      end

      rpcd_pkg::PH_FRAME_LEN: begin
        acc_d  = word_full[23:0];
        wcnt_d = wcnt_q + 2'd1;
        if (word_done) begin
          flen_d = word_full[LW-1:0];
          if (word_full < 32'(rpcd_pkg::HEADER_OVERHEAD)) begin
            res_vld_o = 1'b1;
          end else if (word_full > {8'd0, cfg_i.max_frame}) begin
            res_vld_o = 1'b1;
          end else begin
            fbl_d = word_full[LW-1:0] - LW'(rpcd_pkg::LENGTH_BYTES + 1);
            ph_d  = rpcd_pkg::PH_ID_LEN;
          end
          if (res_vld_o) begin
            res_o.kind   = rpcd_pkg::KIND_STATUS;
            res_o.last   = 1'b1;
            res_o.status = (word_full < 32'(rpcd_pkg::HEADER_OVERHEAD)) ?
                           rpcd_pkg::ST_SHORT : rpcd_pkg::ST_BAD_LEN;
            ph_d         = rpcd_pkg::PH_HUNT;
            wcnt_d       = 2'd0;
            bleft_d      = '0;
          end
        end
      end

      rpcd_pkg::PH_ID_LEN, rpcd_pkg::PH_METHOD_LEN, rpcd_pkg::PH_INFO_LEN: begin
        fbl_d  = fbl_dec;
        acc_d  = word_full[23:0];
        wcnt_d = wcnt_q + 2'd1;
        if (word_done) begin
          if (len_err) begin
            res_vld_o    = 1'b1;
            res_o.kind   = rpcd_pkg::KIND_STATUS;
            res_o.status = rpcd_pkg::ST_BAD_LEN;
            res_o.last   = 1'b1;
            ph_d         = rpcd_pkg::PH_HUNT;
            wcnt_d       = 2'd0;
            bleft_d      = '0;
          end else begin
            sum_d   = len_total[LW-1:0];
            bleft_d = LW'(word_full[15:0]);
            ph_d    = ph_q + 4'd1;
            // An empty string skips straight to what follows it.
            if (len_zero) begin
              if (ph_q == rpcd_pkg::PH_ID_LEN) begin
                ph_d = rpcd_pkg::PH_METHOD_LEN;
              end else if (ph_q == rpcd_pkg::PH_METHOD_LEN) begin
                ph_d = rpcd_pkg::PH_ERR_CODE;
              end else if (pay_len == '0) begin
                bleft_d = LW'(rpcd_pkg::LENGTH_BYTES);
                ph_d    = rpcd_pkg::PH_CHECKSUM;
              end else begin
                bleft_d = pay_len;
                ph_d    = rpcd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
      end

      rpcd_pkg::PH_ID, rpcd_pkg::PH_METHOD, rpcd_pkg::PH_INFO,
      rpcd_pkg::PH_PAYLOAD: begin
        fbl_d      = fbl_dec;
        bleft_d    = bleft_dec;
        res_vld_o  = 1'b1;
        res_o.kind = rpcd_pkg::KIND_CONTENT;
        res_o.tag  = ctag;
        res_o.data = rx_byte_i;
        // Last byte of the part: move on to the next part.
        if (bleft_dec == '0) begin
          wcnt_d = 2'd0;
          if (ph_q == rpcd_pkg::PH_ID) begin
            ph_d = rpcd_pkg::PH_METHOD_LEN;
          end else if (ph_q == rpcd_pkg::PH_METHOD) begin
            ph_d = rpcd_pkg::PH_ERR_CODE;
          end else if ((ph_q == rpcd_pkg::PH_INFO) && (pay_len != '0)) begin
            bleft_d = pay_len;
            ph_d    = rpcd_pkg::PH_PAYLOAD;
          end else begin
            bleft_d = LW'(rpcd_pkg::LENGTH_BYTES);
            ph_d    = rpcd_pkg::PH_CHECKSUM;
          end
        end
      end

      rpcd_pkg::PH_ERR_CODE: begin
        fbl_d  = fbl_dec;
        acc_d  = word_full[23:0];
        wcnt_d = wcnt_q + 2'd1;
        if (word_done) begin
          res_vld_o      = 1'b1;
          res_o.kind     = rpcd_pkg::KIND_WORD;
          res_o.err_word = $signed(word_full);
          ph_d           = rpcd_pkg::PH_INFO_LEN;
        end
      end

      rpcd_pkg::PH_CHECKSUM: begin
        fbl_d   = fbl_dec;
        bleft_d = bleft_dec;
        if (bleft_dec == '0) begin
          ph_d = rpcd_pkg::PH_END;
        end
      end

      default: begin
        // End position: check the closing byte and report the frame.
        fbl_d        = fbl_dec;
        res_vld_o    = 1'b1;
        res_o.kind   = rpcd_pkg::KIND_STATUS;
        res_o.status = (rx_byte_i == cfg_i.end_marker) ?
                       rpcd_pkg::ST_OK : rpcd_pkg::ST_BAD_END;
        res_o.last   = 1'b1;
        ph_d         = rpcd_pkg::PH_HUNT;
        wcnt_d       = 2'd0;
        bleft_d      = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= rpcd_pkg::PH_HUNT;
      wcnt_q  <= 2'd0;
      acc_q   <= 24'd0;
      bleft_q <= '0;
      fbl_q   <= '0;
      sum_q   <= '0;
      flen_q  <= '0;
    end else if (fire_i) begin
      ph_q    <= ph_d;
      wcnt_q  <= wcnt_d;
      acc_q   <= acc_d;
      bleft_q <= bleft_d;
      fbl_q   <= fbl_d;
      sum_q   <= sum_d;
      flen_q  <= flen_d;
    end
  end

endmodule

// File: hw/rtl/rpcd_out_stage.sv
// Output register stage: holds one result word until the receiver takes it.
`timescale 1ns / 1ps

module rpcd_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  rpcd_pkg::res_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rpcd_pkg::res_t res_o
);

  logic           vld_q, vld_d;
  rpcd_pkg::res_t res_q;

  // The slot is free when empty or when its word leaves this cycle.
  assign free_o = ~vld_q | ~out_stall_i;
  assign vld_d  = load_i | (vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/rpc_frame_deframer_core.sv
// Top level of the RPC frame deframer: configuration registers and the stage chain.
`timescale 1ns / 1ps

// Streaming deframer for length-prefixed RPC frames, one received byte per
// input word. Input channel: in_valid_i / in_stall_o / rx_byte_i. Output
// channel: out_valid_o / out_stall_i and the result fields. A word moves at
// a clock edge with valid high and stall low.
// Each byte is captured in an input register, decoded by the parser once the
// output register can take a result, and its result, if any, written to the
// output register, where the result word waits until the receiver takes it.
// Bytes that cause no result (start marker, lengths, checksum) are consumed
// silently.
// Throughput is one byte per cycle while the receiver does not stall.
// Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i while
// the block is idle; the registers take their defaults at reset.
// Reset empties both stages and puts the parser in the hunt for a start
// byte. When the receiver stalls, the output word holds, the parser waits,
// and in_stall_o rises once the input register holds a byte.
module rpc_frame_deframer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_kind_o,
  output logic [1:0]         field_tag_o,
  output logic [7:0]         content_byte_o,
  output logic signed [31:0] error_code_word_o,
  output logic [1:0]         frame_status_o,
  output logic               last_of_frame_o
);

  rpcd_pkg::cfg_t cfg_q;
  rpcd_pkg::res_t res_p;
  rpcd_pkg::res_t res_out;
  logic           in_vld;
  logic [7:0]     in_byte;
  logic           res_vld;
  logic           out_free;
  logic           fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= 8'd2;
      cfg_q.end_marker   <= 8'd3;
      cfg_q.max_field    <= 16'd512;
      cfg_q.max_frame    <= 24'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rpcd_pkg::CFG_START_MARKER: cfg_q.start_marker <= cfg_wdata_i[7:0];
        rpcd_pkg::CFG_END_MARKER:   cfg_q.end_marker   <= cfg_wdata_i[7:0];
        rpcd_pkg::CFG_MAX_FIELD:    cfg_q.max_field    <= cfg_wdata_i[15:0];
        rpcd_pkg::CFG_MAX_FRAME:    cfg_q.max_frame    <= cfg_wdata_i;
        default:                    cfg_q.max_frame    <= cfg_q.max_frame;
      endcase
    end
  end

  // A byte is parsed when one is held and the output slot can take a result.
  assign fire = in_vld & out_free;

  rpcd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (fire),
    .vld_o      (in_vld),
    .byte_o     (in_byte)
  );

  rpcd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (in_byte),
    .cfg_i     (cfg_q),
    .res_vld_o (res_vld),
    .res_o     (res_p)
  );

  rpcd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire & res_vld),
    .res_i       (res_p),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign out_kind_o        = res_out.kind;
  assign field_tag_o       = res_out.tag;
  assign content_byte_o    = res_out.data;
  assign error_code_word_o = res_out.err_word;
  assign frame_status_o    = res_out.status;
  assign last_of_frame_o   = res_out.last;

`ifndef SYNTH
  // Only a status word closes a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_frame_o |-> out_kind_o == rpcd_pkg::KIND_STATUS)
    else $error("last_of_frame on a word that is not a status word");

  // Without receiver backpressure the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output side was free");

  // Field tags are zero outside content words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != rpcd_pkg::KIND_CONTENT |-> field_tag_o == rpcd_pkg::TAG_ID)
    else $error("field tag set on a word that carries no content byte");
`endif

endmodule

// File: test/rpcd_result_checker.sv
// Checker for the RPC frame deframer: predicts result words from accepted bytes and compares.
`timescale 1ns / 1ps

module rpcd_result_checker
  import rpcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         out_kind_i,
  input  logic [1:0]         field_tag_i,
  input  logic [7:0]         content_byte_i,
  input  logic signed [31:0] error_code_word_i,
  input  logic [1:0]         frame_status_i,
  input  logic               last_of_frame_i,
  input  logic               end_of_run_i,
  output int                 err_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 frames_o,
  output int                 good_frames_o,
  output int                 bytes_o
);

  // Shadow copy of the configuration registers.
  cfg_t cfg_copy;

  // Parser state of the prediction.
  logic [3:0]  ph_now;
  logic [31:0] seg_left;
  logic [31:0] frame_rem;
  logic [31:0] acc_word;
  logic [1:0]  acc_cnt;
  logic [31:0] len_sum;
  logic [31:0] frame_len_hdr;

  // Result words predicted but not yet delivered, oldest first.
  res_t expected_words[$];

  // One line per mismatch; printing stops after a few, counting does not.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count_o < 20) begin
      $display("MISMATCH at %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    end
    err_count_o++;
  endtask

  // Shift one byte into the big-endian word; true when four bytes are in.
  function automatic bit word_complete(input logic [7:0] b);
    acc_word = {acc_word[23:0], b};
    if (acc_cnt == 2'd3) begin
      acc_cnt = 2'd0;
      return 1'b1;
    end
    acc_cnt = acc_cnt + 2'd1;
    return 1'b0;
  endfunction

  // Status word that closes a frame; the parser goes back to hunting.
  function automatic res_t close_frame(input logic [1:0] st);
    res_t r;
    r = '0;
    ph_now = PH_HUNT;
    acc_cnt = 2'd0;
    seg_left = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Step past a finished string or payload part.
  function automatic void finish_part(input logic [3:0] ph);
    acc_cnt = 2'd0;
    case (ph)
      PH_ID: ph_now = PH_METHOD_LEN;
      PH_METHOD: ph_now = PH_ERR_CODE;
      PH_INFO: begin
        seg_left = frame_rem - TAIL_BYTES;
        ph_now = PH_PAYLOAD;
        // An empty payload goes straight on to the checksum.
        if (seg_left == 0) begin
          seg_left = LENGTH_BYTES;
          ph_now = PH_CHECKSUM;
        end
      end
      default: begin
        seg_left = LENGTH_BYTES;
        ph_now = PH_CHECKSUM;
      end
    endcase
  endfunction

  // Advance the predicted parser by one byte and give its result word, if any.
  task automatic parse_rx_byte(input logic [7:0] b, output bit produced, output res_t r);
    logic [63:0] total;
    produced = 1'b0;
    r = '0;
    if (ph_now == PH_HUNT) begin
      if (b == cfg_copy.start_marker) begin
        ph_now = PH_FRAME_LEN;
        acc_cnt = 2'd0;
        acc_word = '0;
        len_sum = '0;
      end
    end else if (ph_now == PH_FRAME_LEN) begin
      if (word_complete(b)) begin
        frame_len_hdr = acc_word;
        if (frame_len_hdr < HEADER_OVERHEAD) begin
          r = close_frame(ST_SHORT);
          produced = 1'b1;
        end else if (frame_len_hdr > {8'b0, cfg_copy.max_frame}) begin
          r = close_frame(ST_BAD_LEN);
          produced = 1'b1;
        end else begin
          frame_rem = frame_len_hdr - 32'd1 - LENGTH_BYTES;
          ph_now = PH_ID_LEN;
        end
      end
    end else begin
      frame_rem = frame_rem - 32'd1;
      case (ph_now)
        PH_ID_LEN, PH_METHOD_LEN, PH_INFO_LEN: begin
          if (word_complete(b)) begin
            total = 64'(len_sum) + 64'(acc_word);
            if (acc_word > {16'b0, cfg_copy.max_field} ||
                total > 64'(frame_len_hdr) - HEADER_OVERHEAD) begin
              r = close_frame(ST_BAD_LEN);
              produced = 1'b1;
            end else begin
              len_sum = total[31:0];
              seg_left = acc_word;
              ph_now = ph_now + 4'd1;
              if (seg_left == 0) finish_part(ph_now);
            end
          end
        end
        PH_ID, PH_METHOD, PH_INFO, PH_PAYLOAD: begin
          r.kind = KIND_CONTENT;
          case (ph_now)
            PH_ID: r.tag = TAG_ID;
            PH_METHOD: r.tag = TAG_METHOD;
            PH_INFO: r.tag = TAG_INFO;
            default: r.tag = TAG_PAYLOAD;
          endcase
          r.data = b;
          produced = 1'b1;
          seg_left = seg_left - 32'd1;
          if (seg_left == 0) finish_part(ph_now);
        end
        PH_ERR_CODE: begin
          if (word_complete(b)) begin
            ph_now = PH_INFO_LEN;
            r.kind = KIND_WORD;
            r.err_word = acc_word;
            produced = 1'b1;
          end
        end
        PH_CHECKSUM: begin
          seg_left = seg_left - 32'd1;
          if (seg_left == 0) ph_now = PH_END;
        end
        default: begin
          r = close_frame((b == cfg_copy.end_marker) ? ST_OK : ST_BAD_END);
          produced = 1'b1;
        end
      endcase
    end
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    res_t got;
    bit produced;
    if (!rst_ni) begin
      cfg_copy = '{start_marker: 8'd2, end_marker: 8'd3, max_field: 16'd512,
                   max_frame: 24'd65536};
      ph_now = PH_HUNT;
      seg_left = '0;
      frame_rem = '0;
      acc_word = '0;
      acc_cnt = '0;
      len_sum = '0;
      frame_len_hdr = '0;
      expected_words.delete();
      err_count_o = 0;
      pending_o = 0;
      results_o = 0;
      frames_o = 0;
      good_frames_o = 0;
      bytes_o = 0;
    end else begin
      // Delivered result word against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        got = '0;
        got.kind = out_kind_i;
        got.tag = field_tag_i;
        got.data = content_byte_i;
        got.err_word = error_code_word_i;
        got.status = frame_status_i;
        got.last = last_of_frame_i;
        results_o++;
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected, kind", got.kind, '0);
        end else begin
          want = expected_words.pop_front();
          if (got.kind != want.kind) report_mismatch("out_kind", got.kind, want.kind);
          if (got.tag != want.tag) report_mismatch("field_tag", got.tag, want.tag);
          if (got.data != want.data) report_mismatch("content_byte", got.data, want.data);
          if (got.err_word != want.err_word) begin
            report_mismatch("error_code_word", got.err_word, want.err_word);
          end
          if (got.status != want.status) begin
            report_mismatch("frame_status", got.status, want.status);
          end
          if (got.last != want.last) report_mismatch("last_of_frame", got.last, want.last);
          if (want.kind == KIND_STATUS) begin
            frames_o++;
            if (want.status == ST_OK) good_frames_o++;
          end
        end
      end

      // Register writes.
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_START_MARKER: cfg_copy.start_marker = cfg_wdata_i[7:0];
          CFG_END_MARKER: cfg_copy.end_marker = cfg_wdata_i[7:0];
          CFG_MAX_FIELD: cfg_copy.max_field = cfg_wdata_i[15:0];
          default: cfg_copy.max_frame = cfg_wdata_i;
        endcase
      end

      // Accepted byte: predict what it causes.
      if (in_valid_i && !in_stall_i) begin
        parse_rx_byte(rx_byte_i, produced, want);
        if (produced) expected_words = {expected_words, want};
        bytes_o++;
      end

      // At the end every prediction still waiting is a failure.
      if (end_of_run_i) begin
        while (expected_words.size() > 0) begin
          want = expected_words.pop_front();
          report_mismatch("result word never delivered, kind", '0, want.kind);
        end
      end

      pending_o = expected_words.size();
    end
  end

endmodule

// File: test/tb_rpc_frame_deframer_core.sv
// Testbench top for the RPC frame deframer: byte stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module tb_rpc_frame_deframer_core;
  import rpcd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_START_MARKER;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_stall = 1'b0;
  logic        run_over = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [1:0]         out_kind;
  logic [1:0]         field_tag;
  logic [7:0]         content_byte;
  logic signed [31:0] error_code_word;
  logic [1:0]         frame_status;
  logic               last_of_frame;

  int ck_errors;
  int ck_pending;
  int ck_results;
  int ck_frames;
  int ck_good;
  int ck_bytes;

  // Bytes waiting to be sent, and the settings the generator assumes.
  logic [7:0] byte_stream[$];
  cfg_t       cur_cfg = '{start_marker: 8'd2, end_marker: 8'd3, max_field: 16'd512,
                          max_frame: 24'd65536};
  int         settings_used = 1;

  rpc_frame_deframer_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_kind_o        (out_kind),
    .field_tag_o       (field_tag),
    .content_byte_o    (content_byte),
    .error_code_word_o (error_code_word),
    .frame_status_o    (frame_status),
    .last_of_frame_o   (last_of_frame)
  );

  rpcd_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_kind_i        (out_kind),
    .field_tag_i       (field_tag),
    .content_byte_i    (content_byte),
    .error_code_word_i (error_code_word),
    .frame_status_i    (frame_status),
    .last_of_frame_i   (last_of_frame),
    .end_of_run_i      (run_over),
    .err_count_o       (ck_errors),
    .pending_o         (ck_pending),
    .results_o         (ck_results),
    .frames_o          (ck_frames),
    .good_frames_o     (ck_good),
    .bytes_o           (ck_bytes)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall patterns that change after random stretches, plus one
  // long hold-off once traffic is flowing so the block fills up.
  initial begin : receiver
    int  mode;
    int  seg_cycles;
    bit  hold_done;
    mode = 0;
    seg_cycles = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && ck_results >= 300) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (150) @(negedge clk_i);
      end
      if (seg_cycles == 0) begin
        mode = $urandom_range(0, 3);
        seg_cycles = $urandom_range(10, 80);
      end
      seg_cycles--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Append one byte to the send queue.
  task automatic append_byte(input logic [7:0] b);
    byte_stream = {byte_stream, b};
  endtask

  // Random filler byte. Under large frame limits the start marker is kept out,
  // so a false start cannot open a frame of many thousand bytes.
  function automatic logic [7:0] fill_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (cur_cfg.max_frame > 24'd4096 && v == cur_cfg.start_marker) v = v ^ 8'h80;
    return v;
  endfunction

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) append_byte(w[8*i +: 8]);
  endtask

  // String bytes; a bogus huge length only gets a few bytes behind it.
  task automatic push_string(input logic [31:0] len);
    int unsigned n;
    n = (len > 64) ? 8 : len;
    repeat (n) append_byte(fill_byte());
  endtask

  // One frame as it goes on the wire, with the header values given.
  task automatic push_frame(input logic [31:0] flen, input logic [31:0] id_len,
                            input logic [31:0] m_len, input logic [31:0] info_len,
                            input int unsigned pay_n, input logic [31:0] err_code,
                            input logic [7:0] end_b);
    append_byte(cur_cfg.start_marker);
    push_word(flen);
    push_word(id_len);
    push_string(id_len);
    push_word(m_len);
    push_string(m_len);
    push_word(err_code);
    push_word(info_len);
    push_string(info_len);
    repeat (pay_n) append_byte(fill_byte());
    repeat (4) append_byte(fill_byte());
    append_byte(end_b);
  endtask

  // A well-formed frame with random content, broken now and then.
  task automatic add_random_frame();
    int unsigned room;
    int unsigned lim;
    int unsigned cap;
    int unsigned id_n;
    int unsigned m_n;
    int unsigned i_n;
    int unsigned pay_n;
    int unsigned sum;
    int unsigned pick;
    logic [31:0] flen;
    logic [31:0] id_d;
    logic [31:0] m_d;
    logic [31:0] i_d;
    logic [31:0] bogus;
    logic [7:0]  end_b;
    room = cur_cfg.max_frame - HEADER_OVERHEAD;
    lim = ($urandom_range(0, 7) == 0) ? 40 : 10;
    if (lim > cur_cfg.max_field) lim = 32'(cur_cfg.max_field);
    id_n = $urandom_range(0, (lim < room) ? lim : room);
    room -= id_n;
    m_n = $urandom_range(0, (lim < room) ? lim : room);
    room -= m_n;
    i_n = $urandom_range(0, (lim < room) ? lim : room);
    room -= i_n;
    cap = ($urandom_range(0, 7) == 0) ? 60 : 12;
    pay_n = $urandom_range(0, (cap < room) ? cap : room);
    sum = id_n + m_n + i_n;
    flen = HEADER_OVERHEAD + sum + pay_n;
    id_d = id_n;
    m_d = m_n;
    i_d = i_n;
    end_b = cur_cfg.end_marker;

    // Noise between frames.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 5)) append_byte(fill_byte());
    end

    pick = $urandom_range(0, 19);
    case (pick)
      0: end_b = cur_cfg.end_marker + 8'($urandom_range(1, 255));
      1: begin
        // Bad end byte equal to the start marker.
        end_b = cur_cfg.start_marker;
        if (end_b == cur_cfg.end_marker) end_b = end_b + 8'd1;
      end
      2: flen = $urandom_range(0, HEADER_OVERHEAD - 1);
      3: begin
        if ($urandom_range(0, 3) == 0) flen = 32'hFFFF_FFFF;
        else flen = {8'b0, cur_cfg.max_frame} + 32'd1 + $urandom_range(0, 500);
      end
      4: begin
        // One string longer than the field limit.
        bogus = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
                {16'b0, cur_cfg.max_field} + 32'd1 + $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: id_d = bogus;
          1: m_d = bogus;
          default: i_d = bogus;
        endcase
      end
      5: begin
        // Strings that together overrun the frame.
        if (sum > 0) flen = HEADER_OVERHEAD + sum - 1;
        else flen = $urandom_range(0, HEADER_OVERHEAD - 1);
      end
      6: begin
        // Frame length off by a little: the end lands elsewhere.
        if ($urandom_range(0, 1) == 0) flen = flen + $urandom_range(1, 3);
        else if (flen > HEADER_OVERHEAD + 3) flen = flen - $urandom_range(1, 3);
        else flen = flen + 1;
      end
      default: ;
    endcase

    push_frame(flen, id_d, m_d, i_d, pay_n, $urandom, end_b);
    // Truncated frame: the next frame's bytes land inside this one.
    if (pick == 7) repeat ($urandom_range(1, 20)) void'(byte_stream.pop_back());
  endtask

  // Send the queued bytes in bursts with random gaps.
  task automatic drain_stream();
    int burst;
    int gap;
    burst = 0;
    while (byte_stream.size() > 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst = $urandom_range(1, 24);
      end
      in_valid <= 1'b1;
      rx_byte <= byte_stream.pop_front();
      @(posedge clk_i);
      while (in_stall) @(posedge clk_i);
      @(negedge clk_i);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted word is out, then let the pipeline settle.
  task automatic wait_idle();
    while (ck_pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Write all four registers while the block is idle.
  task automatic apply_settings(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_START_MARKER;
    cfg_wdata <= {16'b0, c.start_marker};
    @(negedge clk_i);
    cfg_addr <= CFG_END_MARKER;
    cfg_wdata <= {16'b0, c.end_marker};
    @(negedge clk_i);
    cfg_addr <= CFG_MAX_FIELD;
    cfg_wdata <= {8'b0, c.max_field};
    @(negedge clk_i);
    cfg_addr <= CFG_MAX_FRAME;
    cfg_wdata <= c.max_frame;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  task automatic run_random_phase(input cfg_t c, input int unsigned nbytes);
    wait_idle();
    apply_settings(c);
    while (byte_stream.size() < nbytes) add_random_frame();
    drain_stream();
  endtask

  initial begin : stimulus
    cfg_t c;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset settings. Stray bytes while hunting,
    // the end marker among them.
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(cur_cfg.end_marker);
    // Smallest frame: every string and the payload empty.
    push_frame(26, 0, 0, 0, 0, 32'h8000_0000, cur_cfg.end_marker);
    // One byte in each string, two payload bytes.
    push_frame(31, 1, 1, 1, 2, 32'h7FFF_FFFF, cur_cfg.end_marker);
    // Bad end byte that equals the start marker, then a good frame.
    push_frame(28, 1, 0, 1, 0, 32'hFFFF_FFFF, cur_cfg.start_marker);
    push_frame(27, 0, 0, 0, 1, 32'h0000_0000, cur_cfg.end_marker);
    // Too short.
    push_frame(25, 1, 0, 0, 0, 32'h1234_5678, cur_cfg.end_marker);
    push_frame(0, 1, 0, 0, 0, 32'h1234_5678, cur_cfg.end_marker);
    // Longer than the frame limit.
    push_frame(65537, 1, 0, 0, 0, 32'h1234_5678, cur_cfg.end_marker);
    push_frame(32'hFFFF_FFFF, 1, 0, 0, 0, 32'h1234_5678, cur_cfg.end_marker);
    // String longer than the field limit, first and last string.
    push_frame(26 + 513, 513, 0, 0, 0, 32'h1, cur_cfg.end_marker);
    push_frame(26 + 600, 0, 0, 600, 0, 32'h1, cur_cfg.end_marker);
    // Strings that overrun the frame length.
    push_frame(30, 3, 5, 0, 0, 32'h1, cur_cfg.end_marker);
    drain_stream();

    // Frame limit below the fixed overhead.
    wait_idle();
    apply_settings('{start_marker: 8'd2, end_marker: 8'd3, max_field: 16'd512,
                     max_frame: 24'd10});
    push_frame(26, 0, 0, 0, 0, 32'h5, cur_cfg.end_marker);
    push_frame(20, 0, 0, 0, 0, 32'h5, cur_cfg.end_marker);
    push_frame(10, 0, 0, 0, 0, 32'h5, cur_cfg.end_marker);
    drain_stream();

    // Random traffic under several settings, extremes among them.
    run_random_phase('{start_marker: 8'hFF, end_marker: 8'h00, max_field: 16'hFFFF,
                       max_frame: 24'hFF_FFFF}, 200);
    run_random_phase('{start_marker: 8'h00, end_marker: 8'hFF, max_field: 16'd0,
                       max_frame: 24'd26}, 120);
    c.start_marker = 8'($urandom);
    c.end_marker = c.start_marker + 8'($urandom_range(1, 255));
    c.max_field = 16'($urandom_range(4, 40));
    c.max_frame = 24'($urandom_range(40, 300));
    run_random_phase(c, 220);
    run_random_phase('{start_marker: 8'd2, end_marker: 8'd3, max_field: 16'd512,
                       max_frame: 24'd65536}, 220);

    // Drain, flag anything still expected, then give the verdict.
    wait_idle();
    repeat (4) @(negedge clk_i);
    run_over <= 1'b1;
    @(negedge clk_i);
    run_over <= 1'b0;
    @(negedge clk_i);
    $display("Covered %0d stream bytes under %0d register settings.",
             ck_bytes, settings_used);
    $display("Checked %0d result words; %0d frames closed, %0d of them good.",
             ck_results, ck_frames, ck_good);
    if (ck_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rpcd_pkg.sv
hw/rtl/rpcd_in_stage.sv
hw/rtl/rpcd_parser.sv
hw/rtl/rpcd_out_stage.sv
hw/rtl/rpc_frame_deframer_core.sv
test/rpcd_result_checker.sv
test/tb_rpc_frame_deframer_core.sv
